// ----- rtl/pprast_pkg.sv -----
// Shared constants, command codes and types for the page-packed rasterizer.
// No dependencies.
package pprast_pkg;
  localparam int DisplayWidth = 128;
  localparam int DisplayHeight = 64;
  localparam int PageRows = 8;
  localparam int CoordW = 11;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_PIXEL = 3'd1,
    MODE_RECT  = 3'd2,
    MODE_ROUND = 3'd3,
    MODE_TRI   = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;

  typedef struct packed {
    logic start;
    logic signed [23:0] num;
    logic signed [12:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [23:0] quo;
  } div_rsp_t;
endpackage

// ----- rtl/pprast_div.sv -----
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on pprast_pkg.
module pprast_div (
  input  logic                clk,
  input  logic                rst,
  input  pprast_pkg::div_req_t req,
  output pprast_pkg::div_rsp_t rsp
);
  logic [23:0] rem_mag;
  logic [23:0] quo;
  logic [23:0] num_mag;
  logic [12:0] den_mag;
  logic [4:0]  cnt;
  logic        neg;
  logic        busy;
  logic        done;
  logic [24:0] trial;

  assign trial = {rem_mag, num_mag[23]} - {12'd0, den_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        neg <= req.num[23] ^ req.den[12];
        num_mag <= req.num[23] ? 24'(-req.num) : 24'(req.num);
        den_mag <= req.den[12] ? 13'(-req.den) : 13'(req.den);
        rem_mag <= '0;
        quo <= '0;
        cnt <= 5'd24;
      end else if (busy) begin
        num_mag <= {num_mag[22:0], 1'b0};
        if (!trial[24]) begin
          rem_mag <= trial[23:0];
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem_mag <= {rem_mag[22:0], num_mag[23]};
          quo <= {quo[22:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = neg ? 24'(-quo) : quo;
endmodule

// ----- rtl/page_packed_primitive_rasterizer_core.sv -----
// Top level of the page-packed monochrome rasterizer: command sequencer and
// frame memory. Depends on pprast_pkg and pprast_div.

// One command is taken at a time and one result beat follows it. Each drawn
// pixel costs a walk step and a read-modify-write of the frame memory (S_PIX
// then S_PIXW), and rows and columns are clipped as the walk goes; a rounded
// corner also tests each mirrored offset. A triangle uses the shared divider
// once per edge crossing per row. A read passes S_READ and S_READW, and a full
// clear writes each frame byte in turn. After reset a clearing pass over every
// frame byte runs while no command is taken.
module page_packed_primitive_rasterizer_core #(
  parameter int DISPLAY_WIDTH = pprast_pkg::DisplayWidth,
  parameter int DISPLAY_HEIGHT = pprast_pkg::DisplayHeight
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic signed [10:0] ax,
  input  logic signed [10:0] ay,
  input  logic signed [10:0] bx,
  input  logic signed [10:0] by,
  input  logic signed [10:0] cx,
  input  logic signed [10:0] cy,
  input  logic signed [10:0] radius,
  input  logic              color,
  input  logic [9:0]        byte_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_data,
  output logic              done_res
);
  localparam int Pages = (DISPLAY_HEIGHT + pprast_pkg::PageRows - 1) / pprast_pkg::PageRows;
  localparam int Bytes = Pages * DISPLAY_WIDTH;
  localparam int AddrW = $clog2(Bytes);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_BOX, S_CORNER, S_TRIROW, S_TRIDIV, S_SPAN,
    S_PIX, S_PIXW, S_READ, S_READW, S_OUT
  } state_t;

  state_t state, ret;
  logic [7:0] mem [Bytes];
  logic [7:0] rd;
  logic [AddrW-1:0] raddr, waddr;
  logic [7:0] wdata;
  logic we;

  logic on;
  logic [AddrW:0] clr_idx;
  logic signed [12:0] vx [3];
  logic signed [12:0] vy [3];
  logic signed [12:0] bx0, bx1, by1, cur_x, cur_y, rr, ox, oy, pxx, pxy;
  logic signed [12:0] ow, oh;
  logic [AddrW-1:0] rd_addr;
  logic rd_ok;
  logic [2:0] phase;
  logic [1:0] edge_k;
  logic [1:0] ncross;
  logic signed [12:0] xs0, xs1;
  logic signed [12:0] cpx, cpy;
  logic [1:0] corner;
  logic [7:0] rdata;
  logic pending;

  pprast_pkg::div_req_t dreq;
  pprast_pkg::div_rsp_t drsp;

  pprast_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // Pixel write address and mask for (pxx, pxy).
  logic pix_in;
  logic [AddrW-1:0] pix_addr;
  logic [7:0] pix_mask;
  assign pix_in = pxx >= 0 && pxx < DISPLAY_WIDTH && pxy >= 0 && pxy < DISPLAY_HEIGHT;
  assign pix_addr = AddrW'(32'(pxy >>> 3) * DISPLAY_WIDTH + 32'(pxx));
  assign pix_mask = 8'd1 << pxy[2:0];

  // Triangle edge k test and operands.
  logic [1:0] ej;
  logic signed [12:0] eya, eyb, exa, exb;
  logic crosses;
  assign ej = (edge_k == 2'd2) ? 2'd0 : edge_k + 2'd1;
  assign eya = vy[edge_k];
  assign eyb = vy[ej];
  assign exa = vx[edge_k];
  assign exb = vx[ej];
  assign crosses = (eya <= cur_y && eyb > cur_y) || (eyb <= cur_y && eya > cur_y);

  // Rounded-corner test for offset (cpx, cpy) at radius rr.
  logic signed [12:0] cdx, cdy;
  logic [25:0] dsq;
  logic corner_on;
  assign cdx = rr - 13'sd1 - cpx;
  assign cdy = rr - 13'sd1 - cpy;
  assign dsq = 26'(cdx * cdx) + 26'(cdy * cdy);
  assign corner_on = dsq <= 26'(rr * rr);

  logic signed [12:0] sw, sh, sr, lim, tlo, thi;
  assign sw = 13'(bx);
  assign sh = 13'(by);
  assign sr = 13'(radius);
  assign lim = ((sw < sh) ? sw : sh) / 13'sd2;
  assign tlo = (ay < by) ? ((ay < cy) ? 13'(ay) : 13'(cy)) : ((by < cy) ? 13'(by) : 13'(cy));
  assign thi = (ay > by) ? ((ay > cy) ? 13'(ay) : 13'(cy)) : ((by > cy) ? 13'(by) : 13'(cy));

  logic signed [12:0] box_col;
  assign box_col = (cur_x < bx0) ? bx0 : cur_x;

  assign in_ready = state == S_IDLE && !pending;
  assign out_valid = state == S_OUT;
  assign read_data = rdata;
  assign done_res = 1'b1;

  always_comb begin
    we = 1'b0;
    waddr = pix_addr;
    wdata = on ? (rd | pix_mask) : (rd & ~pix_mask);
    raddr = pix_addr;
    dreq.start = 1'b0;
    dreq.num = 24'((exb - exa) * (cur_y - eya));
    dreq.den = eyb - eya;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_idx[AddrW-1:0];
      wdata = '0;
    end else if (state == S_PIXW) begin
      we = pix_in;
    end else if (state == S_READ) begin
      raddr = rd_addr;
    end else if (state == S_TRIROW && cur_y <= by1 && edge_k != 2'd3 && ncross != 2'd2 &&
                 crosses) begin
      dreq.start = 1'b1;
    end
  end

  // Command sequencer. Box walk: rectangle bounds bx0..bx1, rows cur_y..by1, clipped on the fly.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pending <= 1'b0;
      clr_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            on <= color;
            rdata <= '0;
            vx[0] <= 13'(ax); vx[1] <= 13'(bx); vx[2] <= 13'(cx);
            vy[0] <= 13'(ay); vy[1] <= 13'(by); vy[2] <= 13'(cy);
            ox <= 13'(ax);
            oy <= 13'(ay);
            ow <= sw;
            oh <= sh;
            rd_addr <= AddrW'(byte_address);
            rd_ok <= 32'(byte_address) < Bytes;
            unique case (mode)
              pprast_pkg::MODE_CLEAR: begin
                clr_idx <= '0;
                pending <= 1'b1;
                state <= S_CLEAR;
              end
              pprast_pkg::MODE_PIXEL: begin
                pxx <= 13'(ax);
                pxy <= 13'(ay);
                ret <= S_OUT;
                state <= S_PIX;
              end
              pprast_pkg::MODE_RECT, pprast_pkg::MODE_ROUND: begin
                phase <= 3'd0;
                if (mode == pprast_pkg::MODE_RECT || sr < 1) begin
                  rr <= '0;
                  phase <= 3'd3;
                  bx0 <= 13'(ax); bx1 <= 13'(ax) + sw - 13'sd1;
                  cur_y <= 13'(ay); by1 <= 13'(ay) + sh - 13'sd1;
                end else begin
                  rr <= (sr > lim) ? lim : sr;
                  bx0 <= '0; bx1 <= -13'sd1; cur_y <= '0; by1 <= -13'sd1;
                end
                cur_x <= 13'(ax);
                state <= S_BOX;
              end
              pprast_pkg::MODE_TRI: begin
                cur_y <= (tlo < 0) ? 13'sd0 : tlo;
                by1 <= (thi > DISPLAY_HEIGHT - 1) ? 13'(DISPLAY_HEIGHT - 1) : thi;
                edge_k <= '0;
                ncross <= '0;
                state <= S_TRIROW;
              end
              pprast_pkg::MODE_READ: state <= S_READ;
              default: state <= S_OUT;
            endcase
            cur_x <= 13'(ax);
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (AddrW+1)'(Bytes - 1)) begin
            state <= pending ? S_OUT : S_IDLE;
            pending <= 1'b0;
          end
        end
        S_BOX: begin
          // Walk the current box row by row; on completion load the next part.
          if (bx1 >= bx0 && cur_y <= by1 && ow > 0 && oh > 0 && !(cur_y < 0 && by1 < 0)) begin
            if (cur_y < 0) begin
              cur_y <= 13'sd0;
            end else if (cur_y >= DISPLAY_HEIGHT) begin
              cur_y <= by1 + 13'sd1;
            end else begin
              pxx <= box_col;
              pxy <= cur_y;
              if (box_col >= bx1 || box_col >= DISPLAY_WIDTH - 1) begin
                cur_x <= -13'sd2048;
                cur_y <= cur_y + 13'sd1;
              end else begin
                cur_x <= box_col + 13'sd1;
              end
              if (box_col < 0) begin
                cur_x <= 13'sd0;
              end else if (box_col > bx1 || box_col > DISPLAY_WIDTH - 1) begin
                cur_x <= -13'sd2048;
                cur_y <= cur_y + 13'sd1;
              end else begin
                ret <= S_BOX;
                state <= S_PIX;
              end
            end
          end else begin
            cur_x <= -13'sd2048;
            phase <= phase + 3'd1;
            unique case (phase)
              3'd0: begin
                bx0 <= ox + rr; bx1 <= ox + ow - rr - 13'sd1;
                cur_y <= oy; by1 <= oy + oh - 13'sd1;
              end
              3'd1: begin
                bx0 <= ox; bx1 <= ox + rr - 13'sd1;
                cur_y <= oy + rr; by1 <= oy + oh - rr - 13'sd1;
              end
              3'd2: begin
                bx0 <= ox + ow - rr; bx1 <= ox + ow - 13'sd1;
                cur_y <= oy + rr; by1 <= oy + oh - rr - 13'sd1;
              end
              3'd3: begin
                cpx <= '0; cpy <= '0; corner <= '0;
                state <= (rr > 0) ? S_CORNER : S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_CORNER: begin
          corner <= corner + 2'd1;
          if (corner == 2'd3) begin
            if (cpx == rr - 13'sd1) begin
              cpx <= '0;
              cpy <= cpy + 13'sd1;
            end else begin
              cpx <= cpx + 13'sd1;
            end
          end
          pxx <= corner[0] ? ox + ow - 13'sd1 - cpx : ox + cpx;
          pxy <= corner[1] ? oy + oh - 13'sd1 - cpy : oy + cpy;
          if (corner == 2'd3 && cpx == rr - 13'sd1 && cpy == rr - 13'sd1)
            ret <= S_OUT;
          else
            ret <= S_CORNER;
          if (corner_on) state <= S_PIX;
          else if (corner == 2'd3 && cpx == rr - 13'sd1 && cpy == rr - 13'sd1) state <= S_OUT;
        end
        S_TRIROW: begin
          if (cur_y > by1) begin
            state <= S_OUT;
          end else if (edge_k == 2'd3 || ncross == 2'd2) begin
            if (ncross == 2'd2) begin
              bx0 <= (xs0 > xs1) ? xs1 : xs0;
              bx1 <= (xs0 > xs1) ? xs0 : xs1;
              cur_x <= -13'sd2048;
              state <= S_SPAN;
            end else begin
              cur_y <= cur_y + 13'sd1;
            end
            edge_k <= '0;
            ncross <= '0;
          end else if (crosses) begin
            state <= S_TRIDIV;
          end else begin
            edge_k <= edge_k + 2'd1;
          end
        end
        S_TRIDIV: begin
          if (drsp.done) begin
            if (ncross == 2'd0) xs0 <= 13'(exa + 13'(drsp.quo));
            else xs1 <= 13'(exa + 13'(drsp.quo));
            ncross <= ncross + 2'd1;
            edge_k <= edge_k + 2'd1;
            state <= S_TRIROW;
          end
        end
        S_SPAN: begin
          if (cur_x < bx0) begin
            cur_x <= (bx0 < 0) ? 13'sd0 : bx0;
          end else if (cur_x > bx1 || cur_x > DISPLAY_WIDTH - 1) begin
            cur_y <= cur_y + 13'sd1;
            state <= S_TRIROW;
          end else begin
            pxx <= cur_x;
            pxy <= cur_y;
            cur_x <= cur_x + 13'sd1;
            ret <= S_SPAN;
            state <= S_PIX;
          end
        end
        S_PIX: state <= S_PIXW;
        S_PIXW: state <= ret;
        S_READ: state <= S_READW;
        S_READW: begin
          if (rd_ok) rdata <= rd;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result beat dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result waits");
  a_div: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_TRIDIV) else $error("stray divider result");
`endif
endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for page_packed_primitive_rasterizer_core: drives
// draw and read commands and compares every result beat with a framebuffer
// predictor kept here or a preset byte. Depends on pprast_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;
  localparam int DispW = pprast_pkg::DisplayWidth;
  localparam int DispH = pprast_pkg::DisplayHeight;
  localparam int Rows = pprast_pkg::PageRows;
  localparam int FrameBytes = ((DispH + Rows - 1) / Rows) * DispW;
  localparam int RandomCmds = 930;
  localparam longint CycleLimit = 8000000;

  typedef struct {
    logic [2:0] op;
    int ax, ay, bx, by, cx, cy, rad;
    bit color;
    int addr;
    bit typed;
    logic [7:0] want;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] mode = '0;
  logic signed [10:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0, radius = '0;
  logic color = 1'b0;
  logic [9:0] byte_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] read_data;
  logic done_res;

  logic [7:0] frame_model [FrameBytes];
  logic [7:0] pending_bytes [$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  int out_stall = 0;

  page_packed_primitive_rasterizer_core dut (.*);

  always #4 clk = ~clk;

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= DispW || y < 0 || y >= DispH) return;
    idx = (y / Rows) * DispW + x;
    frame_model[idx][y % Rows] = on;
  endfunction

  function automatic void span(int x0, int x1, int y, bit on);
    if (y < 0 || y >= DispH) return;
    if (x0 < 0) x0 = 0;
    if (x1 > DispW - 1) x1 = DispW - 1;
    for (int x = x0; x <= x1; x++) plot(x, y, on);
  endfunction

  function automatic void box(int x, int y, int w, int h, bit on);
    int r0, r1;
    r0 = y;
    r1 = y + h - 1;
    if (w <= 0 || h <= 0) return;
    if (r0 < 0) r0 = 0;
    if (r1 > DispH - 1) r1 = DispH - 1;
    for (int row = r0; row <= r1; row++) span(x, x + w - 1, row, on);
  endfunction

  function automatic void rounded_box(int x, int y, int w, int h, int r, bit on);
    int lim, dx, dy;
    if (r < 1) begin
      box(x, y, w, h, on);
      return;
    end
    lim = (w < h ? w : h) / 2;
    if (r > lim) r = lim;
    box(x + r, y, w - 2 * r, h, on);
    box(x, y + r, r, h - 2 * r, on);
    box(x + w - r, y + r, r, h - 2 * r, on);
    for (int py = 0; py < r; py++) begin
      for (int px = 0; px < r; px++) begin
        dx = r - 1 - px;
        dy = r - 1 - py;
        if (dx * dx + dy * dy <= r * r) begin
          plot(x + px, y + py, on);
          plot(x + w - 1 - px, y + py, on);
          plot(x + px, y + h - 1 - py, on);
          plot(x + w - 1 - px, y + h - 1 - py, on);
        end
      end
    end
  endfunction

  function automatic void triangle(int vx[3], int vy[3], bit on);
    int lo, hi, n, j, xa, xb, ya, yb;
    int xs[2];
    lo = vy[0];
    hi = vy[0];
    for (int k = 1; k < 3; k++) begin
      if (vy[k] < lo) lo = vy[k];
      if (vy[k] > hi) hi = vy[k];
    end
    if (lo < 0) lo = 0;
    if (hi > DispH - 1) hi = DispH - 1;
    for (int y = lo; y <= hi; y++) begin
      n = 0;
      for (int k = 0; k < 3 && n < 2; k++) begin
        j = (k + 1) % 3;
        ya = vy[k]; yb = vy[j]; xa = vx[k]; xb = vx[j];
        if ((ya <= y && yb > y) || (yb <= y && ya > y)) begin
          xs[n] = xa + (xb - xa) * (y - ya) / (yb - ya);
          n++;
        end
      end
      if (n == 2) begin
        if (xs[0] > xs[1]) span(xs[1], xs[0], y, on);
        else span(xs[0], xs[1], y, on);
      end
    end
  endfunction

  function automatic logic [7:0] apply_command(cmd_t c);
    int vx[3], vy[3];
    logic [7:0] data;
    data = '0;
    case (c.op)
      pprast_pkg::MODE_CLEAR: begin
        for (int i = 0; i < FrameBytes; i++) frame_model[i] = '0;
      end
      pprast_pkg::MODE_PIXEL: plot(c.ax, c.ay, c.color);
      pprast_pkg::MODE_RECT: box(c.ax, c.ay, c.bx, c.by, c.color);
      pprast_pkg::MODE_ROUND: rounded_box(c.ax, c.ay, c.bx, c.by, c.rad, c.color);
      pprast_pkg::MODE_TRI: begin
        vx = '{c.ax, c.bx, c.cx};
        vy = '{c.ay, c.by, c.cy};
        triangle(vx, vy, c.color);
      end
      pprast_pkg::MODE_READ: if (c.addr < FrameBytes) data = frame_model[c.addr];
      default: data = '0;
    endcase
    return data;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, int x0, int y0, int x1, int y1, int x2, int y2,
                              int r, bit on, int addr, bit typed, logic [7:0] want);
    cmd_t c;
    c = '{op, x0, y0, x1, y1, x2, y2, r, on, addr, typed, want};
    return c;
  endfunction

  function automatic int full11();
    return int'($signed(11'($urandom)));
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int sel;
    bit wide;
    sel = $urandom_range(0, 99);
    wide = ($urandom_range(0, 9) == 0);
    c = mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0, '0);
    c.ax = wide ? full11() : $urandom_range(0, 143) - 8;
    c.ay = wide ? full11() : $urandom_range(0, 79) - 8;
    c.bx = $urandom_range(0, 22) - 2;
    c.by = $urandom_range(0, 22) - 2;
    c.cx = c.ax + $urandom_range(0, 48) - 24;
    c.cy = c.ay + $urandom_range(0, 48) - 24;
    c.rad = $urandom_range(0, 1) ? full11() : $urandom_range(0, 14) - 2;
    c.color = ($urandom_range(0, 3) != 0);
    c.addr = $urandom_range(0, 1023);
    if (sel < 2) c.op = pprast_pkg::MODE_CLEAR;
    else if (sel < 22) c.op = pprast_pkg::MODE_PIXEL;
    else if (sel < 40) c.op = pprast_pkg::MODE_RECT;
    else if (sel < 55) c.op = pprast_pkg::MODE_ROUND;
    else if (sel < 70) begin
      c.op = pprast_pkg::MODE_TRI;
      c.bx = c.ax + $urandom_range(0, 48) - 24;
      c.by = c.ay + $urandom_range(0, 48) - 24;
    end else if (sel < 98) c.op = pprast_pkg::MODE_READ;
    else c.op = $urandom_range(0, 1) ? ModeSpare6 : ModeSpare7;
    if ($urandom_range(0, 49) == 0) begin
      c.bx = full11();
      c.by = full11();
      c.cx = full11();
      c.cy = full11();
    end
    c.ax = int'($signed(11'(c.ax)));
    c.ay = int'($signed(11'(c.ay)));
    c.bx = int'($signed(11'(c.bx)));
    c.by = int'($signed(11'(c.by)));
    c.cx = int'($signed(11'(c.cx)));
    c.cy = int'($signed(11'(c.cy)));
    return c;
  endfunction

  task automatic send_command(cmd_t c);
    int gap;
    logic [7:0] want;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= c.op;
    ax <= 11'(c.ax);
    ay <= 11'(c.ay);
    bx <= 11'(c.bx);
    by <= 11'(c.by);
    cx <= 11'(c.cx);
    cy <= 11'(c.cy);
    radius <= 11'(c.rad);
    color <= c.color;
    byte_address <= 10'(c.addr);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    want = apply_command(c);
    pending_bytes.push_back(c.typed ? c.want : want);
  endtask

  always @(posedge clk) begin
    int stall;
    stall = out_stall;
    if (out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result beat, read_data %0h", $time, read_data);
        errors++;
      end else begin
        if (read_data !== pending_bytes[0]) begin
          $display("%0t: read_data expected %0h got %0h", $time, pending_bytes[0], read_data);
          errors++;
        end
        if (done_res !== 1'b1) begin
          $display("%0t: done_res expected 1 got %0b", $time, done_res);
          errors++;
        end
        void'(pending_bytes.pop_front());
      end
      stall = quiet ? 0 : $urandom_range(0, 3);
    end else if (stall > 0) begin
      stall--;
    end
    out_stall <= stall;
    out_ready <= (stall == 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cmd_t steps [$];
    for (int i = 0; i < FrameBytes; i++) frame_model[i] = '0;
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b1, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1023, 1'b1, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b1, 8'h01));
    steps.push_back(mk(pprast_pkg::MODE_PIXEL, 127, 63, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1023, 1'b1, 8'h80));
    steps.push_back(mk(pprast_pkg::MODE_PIXEL, -1024, -1024, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0,
                       8'h00));
    steps.push_back(mk(pprast_pkg::MODE_PIXEL, 1023, 1023, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_RECT, -1024, -1024, 1023, 1023, 0, 0, 0, 1'b1, 0, 1'b0,
                       8'h00));
    steps.push_back(mk(pprast_pkg::MODE_RECT, 0, 0, -1024, 5, 0, 0, 0, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_RECT, 120, 60, 1023, 1023, 0, 0, 0, 1'b1, 0, 1'b0,
                       8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1023, 1'b1, 8'hF0));
    steps.push_back(mk(pprast_pkg::MODE_ROUND, 10, 10, 20, 12, 0, 0, 1023, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_ROUND, 40, 5, 9, 7, 0, 0, -1024, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_ROUND, 60, 30, 1, 1, 0, 0, 3, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 138, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_TRI, 0, 20, 127, 20, 60, 20, 0, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_TRI, 10, 5, -1024, 1023, 1023, -1024, 0, 1'b1, 0, 1'b0,
                       8'h00));
    steps.push_back(mk(pprast_pkg::MODE_TRI, 5, 5, 5, 5, 5, 5, 0, 1'b0, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 300, 1'b0, 8'h00));
    steps.push_back(mk(ModeSpare6, 3, 3, 3, 3, 3, 3, 3, 1'b1, 0, 1'b1, 8'h00));
    steps.push_back(mk(ModeSpare7, 3, 3, 3, 3, 3, 3, 3, 1'b1, 1023, 1'b1, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_RECT, 0, 0, 128, 64, 0, 0, 0, 1'b0, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 1'b1, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0, 8'h00));
    steps.push_back(mk(pprast_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1023, 1'b1, 8'h00));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (steps[i]) send_command(steps[i]);

    // Drain everything once with the sender held off.
    in_valid <= 1'b0;
    wait (pending_bytes.size() == 0);
    @(posedge clk);

    for (int i = 0; i < RandomCmds; i++) begin
      if (i % 200 == 100) quiet = 1'b1;
      if (i % 200 == 140) quiet = 1'b0;
      send_command(random_cmd());
    end
    in_valid <= 1'b0;
    wait (pending_bytes.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
